### hdl/edf_pkg.sv
// edf_pkg: request, result and register types, codes and reset values
// for the echo distance filter and drive selector.
// No dependencies.
package edf_pkg;

	localparam int INPUT_FIELDS = 5;
	localparam logic [8:0] RESET_DIST = 9'd400;

	// register indexes
	localparam logic [2:0] REG_MIN_DIST  = 3'd0;
	localparam logic [2:0] REG_MAX_DIST  = 3'd1;
	localparam logic [2:0] REG_CRIT_DIST = 3'd2;
	localparam logic [2:0] REG_WARN_DIST = 3'd3;
	localparam logic [2:0] REG_SLOW_DUTY = 3'd4;
	localparam logic [2:0] REG_FULL_DUTY = 3'd5;
	localparam logic [2:0] REG_ERR_LIMIT = 3'd6;

	// result source codes
	localparam logic [1:0] SRC_FRESH  = 2'd0;
	localparam logic [1:0] SRC_REPEAT = 2'd1;
	localparam logic [1:0] SRC_NONE   = 2'd2;

	// drive zones
	localparam logic [1:0] ZONE_STOP  = 2'd0;
	localparam logic [1:0] ZONE_SLOW  = 2'd1;
	localparam logic [1:0] ZONE_CLEAR = 2'd2;

	typedef struct packed {
		logic [15:0] ticks_0;
		logic [15:0] ticks_1;
		logic [15:0] ticks_2;
		logic [15:0] ticks_3;
		logic [15:0] ticks_4;
	} req_t;

	typedef struct packed {
		logic [8:0] distance_cm;
		logic [1:0] source;
		logic [1:0] zone;
		logic [7:0] drive_duty;
		logic       drive_forward;
	} rsp_t;

	typedef struct packed {
		logic [8:0] min_cm;
		logic [8:0] max_cm;
		logic [8:0] stop_cm;
		logic [8:0] caution_cm;
		logic [7:0] slow_duty;
		logic [7:0] full_duty;
		logic [3:0] error_limit;
	} cfg_t;

	// burst summary handed from the front end to the tracker
	typedef struct packed {
		logic       hit;
		logic [8:0] median;
	} mid_t;

endpackage

### hdl/edf_front.sv
// edf_front: request register, tick to centimetre conversion, window check
// and upper-median selection, registered into the summary stage.
// Depends on edf_pkg.
module edf_front #(
	parameter int READINGS_PER_BURST = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  edf_pkg::req_t req,
	input  edf_pkg::cfg_t cfg,
	output logic          mid_valid,
	input  logic          mid_ready,
	output edf_pkg::mid_t mid
);

	localparam int LANES = (READINGS_PER_BURST < edf_pkg::INPUT_FIELDS) ?
		READINGS_PER_BURST : edf_pkg::INPUT_FIELDS;
	localparam logic [15:0] TICK_TIMEOUT = 16'd60000;
	// x/1000 = (x>>3)/125; 1/125 as 134218 / 2^24, exact for 17-bit x>>3
	localparam logic [34:0] RECIP_125 = 35'd134218;

	function automatic logic [9:0] ticks_to_cm(input logic [15:0] t);
		logic [15:0] v;
		logic [19:0] x;
		logic [34:0] p;
		v = (t > TICK_TIMEOUT) ? TICK_TIMEOUT : t;
		x = {v, 4'b0000} + {4'b0000, v};
		p = {18'd0, x[19:3]} * RECIP_125;
		return p[33:24];
	endfunction

	logic          valid_s1;
	edf_pkg::req_t req_s1;
	logic          valid_s2;
	edf_pkg::mid_t mid_s2;
	logic          adv_s2;

	logic [9:0] cm [edf_pkg::INPUT_FIELDS];
	logic       keep [edf_pkg::INPUT_FIELDS];
	logic [2:0] rank [edf_pkg::INPUT_FIELDS];
	logic [2:0] count;
	logic [8:0] median;

	assign adv_s2    = !valid_s2 || mid_ready;
	assign req_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	assign cm[0] = ticks_to_cm(req_s1.ticks_0);
	assign cm[1] = ticks_to_cm(req_s1.ticks_1);
	assign cm[2] = ticks_to_cm(req_s1.ticks_2);
	assign cm[3] = ticks_to_cm(req_s1.ticks_3);
	assign cm[4] = ticks_to_cm(req_s1.ticks_4);

	always_comb begin
		for (int i = 0; i < edf_pkg::INPUT_FIELDS; i++) begin
			keep[i] = (i < LANES) && (cm[i] >= {1'b0, cfg.min_cm}) &&
				(cm[i] <= {1'b0, cfg.max_cm});
		end
	end

	// rank among kept readings, ties broken by position
	always_comb begin
		count = '0;
		for (int i = 0; i < edf_pkg::INPUT_FIELDS; i++) begin
			count = count + 3'(keep[i]);
		end
		for (int i = 0; i < edf_pkg::INPUT_FIELDS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < edf_pkg::INPUT_FIELDS; j++) begin
				if (keep[j] && ((cm[j] < cm[i]) || ((cm[j] == cm[i]) && (j < i)))) begin
					rank[i] = rank[i] + 3'd1;
				end
			end
		end
		median = '0;
		for (int i = 0; i < edf_pkg::INPUT_FIELDS; i++) begin
			if (keep[i] && (rank[i] == (count >> 1))) begin
				median = cm[i][8:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			mid_s2.hit    <= (count != 3'd0);
			mid_s2.median <= median;
		end
	end

	assign mid_valid = valid_s2;
	assign mid       = mid_s2;

endmodule

### hdl/edf_track.sv
// edf_track: history ring with running sum, error counting, zone and duty
// selection, and the result register.
// Depends on edf_pkg.
module edf_track #(
	parameter int AVERAGE_DEPTH = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mid_valid,
	output logic          mid_ready,
	input  edf_pkg::mid_t mid,
	input  edf_pkg::cfg_t cfg,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output edf_pkg::rsp_t rsp
);

	localparam int SLOT_W    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int SUM_W     = 9 + $clog2(AVERAGE_DEPTH);
	localparam int DIV_SHIFT = SUM_W + $clog2(AVERAGE_DEPTH) + 1;
	localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;
	localparam logic [PROD_W-1:0] RECIP = PROD_W'(
		((longint'(1) << DIV_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);
	localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(400 * AVERAGE_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVERAGE_DEPTH - 1);

	logic [8:0]        ring_q [AVERAGE_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [8:0]        last_good_q;
	logic [3:0]        fail_q;
	logic [1:0]        held_zone_q;
	logic [7:0]        held_duty_q;
	logic              rsp_valid_q;
	edf_pkg::rsp_t     rsp_q;

	logic              fire;
	logic [SUM_W-1:0]  sum_new;
	logic [PROD_W-1:0] prod;
	logic [8:0]        mean;
	logic [4:0]        fail_inc;
	logic [3:0]        fail_new;
	logic [8:0]        out_cm;
	logic [1:0]        src;
	logic [1:0]        zone_new;
	logic [7:0]        duty_new;

	assign mid_ready = !rsp_valid_q || rsp_ready;
	assign fire      = mid_valid && mid_ready;

	assign sum_new  = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(mid.median);
	assign prod     = PROD_W'(sum_new) * RECIP;
	assign mean     = prod[DIV_SHIFT +: 9];
	assign fail_inc = {1'b0, fail_q} + 5'd1;
	assign fail_new = (fail_inc > {1'b0, cfg.error_limit}) ? cfg.error_limit : fail_inc[3:0];

	always_comb begin
		priority if (mid.hit) begin
			out_cm = mean;
			src    = edf_pkg::SRC_FRESH;
		end else if (fail_new >= cfg.error_limit) begin
			out_cm = last_good_q;
			src    = edf_pkg::SRC_REPEAT;
		end else begin
			out_cm = '0;
			src    = edf_pkg::SRC_NONE;
		end
	end

	always_comb begin
		priority if (out_cm == 9'd0) begin
			zone_new = held_zone_q;
			duty_new = held_duty_q;
		end else if (out_cm <= cfg.stop_cm) begin
			zone_new = edf_pkg::ZONE_STOP;
			duty_new = '0;
		end else if (out_cm <= cfg.caution_cm) begin
			zone_new = edf_pkg::ZONE_SLOW;
			duty_new = cfg.slow_duty;
		end else begin
			zone_new = edf_pkg::ZONE_CLEAR;
			duty_new = cfg.full_duty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVERAGE_DEPTH; i++) begin
				ring_q[i] <= edf_pkg::RESET_DIST;
			end
			slot_q      <= '0;
			sum_q       <= SUM_RESET;
			last_good_q <= edf_pkg::RESET_DIST;
			fail_q      <= '0;
			held_zone_q <= edf_pkg::ZONE_STOP;
			held_duty_q <= '0;
		end else if (fire) begin
			held_zone_q <= zone_new;
			held_duty_q <= duty_new;
			if (mid.hit) begin
				ring_q[slot_q] <= mid.median;
				slot_q         <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
				sum_q          <= sum_new;
				last_good_q    <= mean;
				fail_q         <= '0;
			end else begin
				fail_q <= fail_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.distance_cm   <= out_cm;
			rsp_q.source        <= src;
			rsp_q.zone          <= zone_new;
			rsp_q.drive_duty    <= duty_new;
			rsp_q.drive_forward <= (duty_new != 8'd0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("summary taken without a result");

	a_hit_clears_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mid.hit) |=> (fail_q == 4'd0))
		else $error("fail count not cleared on a fresh burst");

	a_fresh_matches_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.source == edf_pkg::SRC_FRESH)) |->
		(rsp_q.distance_cm == last_good_q))
		else $error("fresh result differs from last good distance");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.source == edf_pkg::SRC_NONE)) |->
		(rsp_q.distance_cm == 9'd0))
		else $error("no-reading result carries a distance");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("ring slot out of range");

endmodule

### hdl/echo_distance_filter_drive.sv
// echo_distance_filter_drive: a request passes the request, summary and result
// registers; one request accepted per cycle, stalls only while the result is held.
// Reset clears the pipeline, loads register defaults, fills the history with 400 cm
// and clears the error count and held drive.
// Depends on edf_pkg, edf_front, edf_track.
module echo_distance_filter_drive #(
	parameter int READINGS_PER_BURST = 5,
	parameter int AVERAGE_DEPTH = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  edf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output edf_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  logic [2:0]    cfg_index,
	input  logic [8:0]    cfg_wdata
);

	edf_pkg::cfg_t cfg_q;
	edf_pkg::mid_t mid;
	logic          mid_valid;
	logic          mid_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_cm      <= 9'd2;
			cfg_q.max_cm      <= 9'd400;
			cfg_q.stop_cm     <= 9'd20;
			cfg_q.caution_cm  <= 9'd50;
			cfg_q.slow_duty   <= 8'd100;
			cfg_q.full_duty   <= 8'd200;
			cfg_q.error_limit <= 4'd3;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				edf_pkg::REG_MIN_DIST:  cfg_q.min_cm      <= cfg_wdata;
				edf_pkg::REG_MAX_DIST:  cfg_q.max_cm      <= cfg_wdata;
				edf_pkg::REG_CRIT_DIST: cfg_q.stop_cm     <= cfg_wdata;
				edf_pkg::REG_WARN_DIST: cfg_q.caution_cm  <= cfg_wdata;
				edf_pkg::REG_SLOW_DUTY: cfg_q.slow_duty   <= cfg_wdata[7:0];
				edf_pkg::REG_FULL_DUTY: cfg_q.full_duty   <= cfg_wdata[7:0];
				edf_pkg::REG_ERR_LIMIT: cfg_q.error_limit <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	edf_front #(
		.READINGS_PER_BURST(READINGS_PER_BURST)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg       (cfg_q),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	edf_track #(
		.AVERAGE_DEPTH(AVERAGE_DEPTH)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.cfg       (cfg_q),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
